// File: sv/onu_pkg.sv
// ----------------------------------------------------------------------------
// onu_pkg
// shared types and constants for the octahedral normal encoder
// ----------------------------------------------------------------------------
package onu_pkg;

   // quantized output and range register widths
   localparam int RANGE_W = 16;
   localparam int ENC_W   = 16;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from the word address bit of paddr
   localparam logic [0:0] REG_RANGE_MAX = 1'b0;

   localparam logic [RANGE_W-1:0] RANGE_MAX_RESET = 16'd255;

   // per-transaction sign and zero flags carried down the pipeline
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic zero;
   } onu_flags_type;

endpackage

// File: sv/onu_front.sv
// ----------------------------------------------------------------------------
// onu_front
// first pipeline stage: magnitudes, l1 norm, sign and zero flags
// ----------------------------------------------------------------------------
module onu_front #(
   parameter int COMP_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COMP_BITS-1:0]   comp_x,
   input  logic signed [COMP_BITS-1:0]   comp_y,
   input  logic signed [COMP_BITS-1:0]   comp_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output onu_pkg::onu_flags_type        out_flags,
   output logic [COMP_BITS:0]            out_sum,
   output logic [COMP_BITS-1:0]          out_mag_x,
   output logic [COMP_BITS-1:0]          out_mag_y
);

   localparam int SUM_W = COMP_BITS + 1;

   logic                   valid_ff;
   logic                   valid_in;
   logic                   load;
   onu_pkg::onu_flags_type flags_ff;
   onu_pkg::onu_flags_type flags_in;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;
   logic [COMP_BITS-1:0]   mag_x_ff;
   logic [COMP_BITS-1:0]   mag_x_in;
   logic [COMP_BITS-1:0]   mag_y_ff;
   logic [COMP_BITS-1:0]   mag_y_in;
   logic [COMP_BITS-1:0]   mag_z;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // most negative code maps to magnitude 2^(COMP_BITS-1), still fits
   assign mag_x_in = comp_x[COMP_BITS-1] ? (~$unsigned(comp_x) + COMP_BITS'(1))
                                         : $unsigned(comp_x);
   assign mag_y_in = comp_y[COMP_BITS-1] ? (~$unsigned(comp_y) + COMP_BITS'(1))
                                         : $unsigned(comp_y);
   assign mag_z    = comp_z[COMP_BITS-1] ? (~$unsigned(comp_z) + COMP_BITS'(1))
                                         : $unsigned(comp_z);

   assign sum_in = SUM_W'(mag_x_in) + SUM_W'(mag_y_in) + SUM_W'(mag_z);

   always_comb begin
      flags_in.neg_x = comp_x[COMP_BITS-1];
      flags_in.neg_y = comp_y[COMP_BITS-1];
      flags_in.neg_z = comp_z[COMP_BITS-1];
      flags_in.zero  = (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= flags_in;
         sum_ff   <= sum_in;
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_sum   = sum_ff;
   assign out_mag_x = mag_x_ff;
   assign out_mag_y = mag_y_ff;

endmodule

// File: sv/onu_div_step.sv
// ----------------------------------------------------------------------------
// onu_div_step
// one restoring division step for the x and y quotients, one bit per stage
// ----------------------------------------------------------------------------
module onu_div_step #(
   parameter int COMP_BITS = 16,
   parameter bit FIRST     = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  onu_pkg::onu_flags_type    in_flags,
   input  logic [COMP_BITS:0]        in_sum,
   input  logic [COMP_BITS:0]        in_rem_x,
   input  logic [COMP_BITS:0]        in_rem_y,
   input  logic [COMP_BITS-1:0]      in_quo_x,
   input  logic [COMP_BITS-1:0]      in_quo_y,
   output logic                      out_valid,
   input  logic                      out_ready,
   output onu_pkg::onu_flags_type    out_flags,
   output logic [COMP_BITS:0]        out_sum,
   output logic [COMP_BITS:0]        out_rem_x,
   output logic [COMP_BITS:0]        out_rem_y,
   output logic [COMP_BITS-1:0]      out_quo_x,
   output logic [COMP_BITS-1:0]      out_quo_y
);

   localparam int SUM_W = COMP_BITS + 1;

   logic                   valid_ff;
   logic                   valid_in;
   logic                   load;
   onu_pkg::onu_flags_type flags_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       rem_x_ff;
   logic [SUM_W-1:0]       rem_x_in;
   logic [SUM_W-1:0]       rem_y_ff;
   logic [SUM_W-1:0]       rem_y_in;
   logic [COMP_BITS-1:0]   quo_x_ff;
   logic [COMP_BITS-1:0]   quo_x_in;
   logic [COMP_BITS-1:0]   quo_y_ff;
   logic [COMP_BITS-1:0]   quo_y_in;
   logic [SUM_W:0]         sh_x;
   logic [SUM_W:0]         sh_y;
   logic [SUM_W:0]         diff_x;
   logic [SUM_W:0]         diff_y;
   logic                   bit_x;
   logic                   bit_y;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // first step takes the quotient's integer bit without a shift
   assign sh_x = FIRST ? {1'b0, in_rem_x} : {in_rem_x, 1'b0};
   assign sh_y = FIRST ? {1'b0, in_rem_y} : {in_rem_y, 1'b0};

   assign diff_x = sh_x - {1'b0, in_sum};
   assign diff_y = sh_y - {1'b0, in_sum};
   assign bit_x  = !diff_x[SUM_W];
   assign bit_y  = !diff_y[SUM_W];

   // remainder stays below the sum, so SUM_W bits hold it either way
   assign rem_x_in = bit_x ? diff_x[SUM_W-1:0] : sh_x[SUM_W-1:0];
   assign rem_y_in = bit_y ? diff_y[SUM_W-1:0] : sh_y[SUM_W-1:0];
   assign quo_x_in = {in_quo_x[COMP_BITS-2:0], bit_x};
   assign quo_y_in = {in_quo_y[COMP_BITS-2:0], bit_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= in_flags;
         sum_ff   <= in_sum;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_sum   = sum_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_quo_x = quo_x_ff;
   assign out_quo_y = quo_y_ff;

endmodule

// File: sv/onu_quant.sv
// ----------------------------------------------------------------------------
// onu_quant
// fold, bias, scale by range and round: three register stages
// ----------------------------------------------------------------------------
module onu_quant #(
   parameter int COMP_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  onu_pkg::onu_flags_type            in_flags,
   input  logic [COMP_BITS-1:0]              in_quo_x,
   input  logic [COMP_BITS-1:0]              in_quo_y,
   input  logic [onu_pkg::RANGE_W-1:0]       range_max,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [onu_pkg::ENC_W-1:0]         out_enc_x,
   output logic [onu_pkg::ENC_W-1:0]         out_enc_y,
   output logic                              out_zero
);

   localparam int BIAS_W = COMP_BITS + 1;
   localparam int PROD_W = BIAS_W + onu_pkg::RANGE_W;
   localparam logic [BIAS_W-1:0] ONE = BIAS_W'(1) << (COMP_BITS - 1);
   localparam logic [BIAS_W-1:0] TWO = BIAS_W'(1) << COMP_BITS;

   // stage 1: biased coordinate (v + 1.0) in [0, 2.0]
   logic                 v1_ff;
   logic                 rdy1;
   logic                 zero1_ff;
   logic [BIAS_W-1:0]    bx_ff;
   logic [BIAS_W-1:0]    bx_in;
   logic [BIAS_W-1:0]    by_ff;
   logic [BIAS_W-1:0]    by_in;
   logic [BIAS_W-1:0]    qx;
   logic [BIAS_W-1:0]    qy;

   // stage 2: scaled by range
   logic                 v2_ff;
   logic                 rdy2;
   logic                 zero2_ff;
   logic [PROD_W-1:0]    px_ff;
   logic [PROD_W-1:0]    py_ff;

   // stage 3: rounded result
   logic                 v3_ff;
   logic                 rdy3;
   logic                 zero3_ff;
   logic [PROD_W-1:0]    rx;
   logic [PROD_W-1:0]    ry;
   logic [onu_pkg::ENC_W-1:0] ex_ff;
   logic [onu_pkg::ENC_W-1:0] ex_in;
   logic [onu_pkg::ENC_W-1:0] ey_ff;
   logic [onu_pkg::ENC_W-1:0] ey_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign qx = BIAS_W'(in_quo_x);
   assign qy = BIAS_W'(in_quo_y);

   // fold uses the input signs; -(1 - |q|) + 1 reduces to |q|
   always_comb begin
      if (in_flags.neg_z) begin
         bx_in = in_flags.neg_x ? qy : (TWO - qy);
         by_in = in_flags.neg_y ? qx : (TWO - qx);
      end else begin
         bx_in = in_flags.neg_x ? (ONE - qx) : (ONE + qx);
         by_in = in_flags.neg_y ? (ONE - qy) : (ONE + qy);
      end
   end

   assign rx    = px_ff + PROD_W'(ONE);
   assign ry    = py_ff + PROD_W'(ONE);
   assign ex_in = zero2_ff ? '0 : rx[COMP_BITS +: onu_pkg::ENC_W];
   assign ey_in = zero2_ff ? '0 : ry[COMP_BITS +: onu_pkg::ENC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy1) begin
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         zero1_ff <= in_flags.zero;
      end
      if (v1_ff && rdy2) begin
         px_ff    <= PROD_W'(bx_ff) * PROD_W'(range_max);
         py_ff    <= PROD_W'(by_ff) * PROD_W'(range_max);
         zero2_ff <= zero1_ff;
      end
      if (v2_ff && rdy3) begin
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         zero3_ff <= zero2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_enc_x = ex_ff;
   assign out_enc_y = ey_ff;
   assign out_zero  = zero3_ff;

endmodule

// File: sv/oct_normal_encoder_unit.sv
// ----------------------------------------------------------------------------
// oct_normal_encoder_unit
// octahedral encoder for signed q1.(COMP_BITS-1) unit vectors, quantized to
// 0..range_max per coordinate, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel   direction  ports                       transaction
//  req       in         req_valid/req_ready         comp_x, comp_y, comp_z
//  rsp       out        rsp_valid/rsp_ready         enc_x, enc_y, zero_vector
//  csr       in         psel/penable/pwrite/...     range_max at byte 0
//
//  one transaction enters per cycle while rsp does not stall; the path runs
//  through 1 norm stage, COMP_BITS restoring division stages, 3 quantize stages,
//  the divider taking one bit per stage for the x and y quotients
//  every stage has its own valid bit and a ready that looks one stage ahead,
//  so a stall on rsp fills bubbles first and drops or repeats nothing
//  reset clears all valid bits and sets range_max to 255
// ----------------------------------------------------------------------------
module oct_normal_encoder_unit #(
   parameter int COMP_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COMP_BITS-1:0]         req_comp_x,
   input  logic signed [COMP_BITS-1:0]         req_comp_y,
   input  logic signed [COMP_BITS-1:0]         req_comp_z,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [onu_pkg::ENC_W-1:0]           rsp_enc_x,
   output logic [onu_pkg::ENC_W-1:0]           rsp_enc_y,
   output logic                                rsp_zero_vector,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [onu_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [onu_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [onu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int SUM_W = COMP_BITS + 1;
   localparam int NDIV  = COMP_BITS;   // one quotient bit per stage

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [onu_pkg::RANGE_W-1:0] range_max_ff;
   logic [onu_pkg::RANGE_W-1:0] range_max_in;
   logic                        csr_write;
   logic                        csr_sel_range;

   // word address bit picks the register, byte offset bits are ignored
   assign csr_sel_range = (csr_paddr[onu_pkg::CSR_ADDR_W-1] == onu_pkg::REG_RANGE_MAX);
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready    = 1'b1;

   assign range_max_in = (csr_write && csr_sel_range)
                         ? csr_pwdata[onu_pkg::RANGE_W-1:0] : range_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_max_ff <= onu_pkg::RANGE_MAX_RESET;
      end else begin
         range_max_ff <= range_max_in;
      end
   end

   // reads outside the register return zero
   assign csr_prdata = csr_sel_range ? onu_pkg::CSR_DATA_W'(range_max_ff) : '0;

   // ------------------------------------------------------------------
   // norm stage: |x|+|y|+|z|, signs, zero vector detect
   // ------------------------------------------------------------------
   logic                   d_valid [0:NDIV];
   logic                   d_ready [0:NDIV];
   onu_pkg::onu_flags_type d_flags [0:NDIV];
   logic [SUM_W-1:0]       d_sum   [0:NDIV];
   logic [SUM_W-1:0]       d_rem_x [0:NDIV];
   logic [SUM_W-1:0]       d_rem_y [0:NDIV];
   logic [COMP_BITS-1:0]   d_quo_x [0:NDIV];
   logic [COMP_BITS-1:0]   d_quo_y [0:NDIV];
   logic [COMP_BITS-1:0]   mag_x;
   logic [COMP_BITS-1:0]   mag_y;

   onu_front #(
      .COMP_BITS (COMP_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .comp_x    (req_comp_x),
      .comp_y    (req_comp_y),
      .comp_z    (req_comp_z),
      .out_valid (d_valid[0]),
      .out_ready (d_ready[0]),
      .out_flags (d_flags[0]),
      .out_sum   (d_sum[0]),
      .out_mag_x (mag_x),
      .out_mag_y (mag_y)
   );

   // division starts with the magnitude as remainder and an empty quotient
   assign d_rem_x[0] = SUM_W'(mag_x);
   assign d_rem_y[0] = SUM_W'(mag_y);
   assign d_quo_x[0] = '0;
   assign d_quo_y[0] = '0;

   // ------------------------------------------------------------------
   // division pipeline: trunc(|c| * 2^(COMP_BITS-1) / sum) for x and y,
   // msb (integer bit) first; quotient never exceeds 1.0
   // ------------------------------------------------------------------
   for (genvar i = 0; i < NDIV; i++) begin : g_div
      onu_div_step #(
         .COMP_BITS (COMP_BITS),
         .FIRST     (i == 0)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[i]),
         .in_ready  (d_ready[i]),
         .in_flags  (d_flags[i]),
         .in_sum    (d_sum[i]),
         .in_rem_x  (d_rem_x[i]),
         .in_rem_y  (d_rem_y[i]),
         .in_quo_x  (d_quo_x[i]),
         .in_quo_y  (d_quo_y[i]),
         .out_valid (d_valid[i+1]),
         .out_ready (d_ready[i+1]),
         .out_flags (d_flags[i+1]),
         .out_sum   (d_sum[i+1]),
         .out_rem_x (d_rem_x[i+1]),
         .out_rem_y (d_rem_y[i+1]),
         .out_quo_x (d_quo_x[i+1]),
         .out_quo_y (d_quo_y[i+1])
      );
   end

   // ------------------------------------------------------------------
   // fold onto lower hemisphere when z < 0, then bias, scale and round;
   // the last stage register is the response register
   // ------------------------------------------------------------------
   onu_quant #(
      .COMP_BITS (COMP_BITS)
   ) u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid[NDIV]),
      .in_ready  (d_ready[NDIV]),
      .in_flags  (d_flags[NDIV]),
      .in_quo_x  (d_quo_x[NDIV]),
      .in_quo_y  (d_quo_y[NDIV]),
      .range_max (range_max_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_enc_x (rsp_enc_x),
      .out_enc_y (rsp_enc_y),
      .out_zero  (rsp_zero_vector)
   );

   // last remainders and the sum leave the final division stage unused
   logic unused_tail;
   assign unused_tail = ^{d_rem_x[NDIV], d_rem_y[NDIV], d_sum[NDIV]};

endmodule

// File: dv/oct_normal_encoder_checker.sv
// ----------------------------------------------------------------------------
// oct_normal_encoder_checker
// watches the req, rsp and csr ports of the octahedral normal encoder, keeps
// a copy of range_max, predicts the code of every accepted vector and checks
// the responses in order
// ----------------------------------------------------------------------------
module oct_normal_encoder_checker #(
   parameter int COMP_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [COMP_BITS-1:0]         req_comp_x,
   input  logic signed [COMP_BITS-1:0]         req_comp_y,
   input  logic signed [COMP_BITS-1:0]         req_comp_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [onu_pkg::ENC_W-1:0]           rsp_enc_x,
   input  logic [onu_pkg::ENC_W-1:0]           rsp_enc_y,
   input  logic                                rsp_zero_vector,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [onu_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [onu_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [onu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  logic                                csr_pready,
   output int                                  error_count,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FRAC     = COMP_BITS - 1;
   localparam longint UNIT_ONE = longint'(1) <<< FRAC;

   typedef struct packed {
      logic [onu_pkg::ENC_W-1:0] enc_x;
      logic [onu_pkg::ENC_W-1:0] enc_y;
      logic                      zero_vector;
   } oct_code_type;

   oct_code_type                 pending_codes[$];
   logic [onu_pkg::RANGE_W-1:0]  range_shadow = onu_pkg::RANGE_MAX_RESET;

   // map [-1,1] onto [0,rmax], round half up
   function automatic longint quantize_coord(input longint v, input longint rmax);
      longint q;
      q = ((v + UNIT_ONE) * rmax + UNIT_ONE) >>> (FRAC + 1);
      return (q > rmax) ? rmax : q;
   endfunction

   function automatic oct_code_type octahedral_encode(input longint x, input longint y,
                                                      input longint z, input longint rmax);
      longint       s;
      longint       px;
      longint       py;
      longint       fx;
      longint       fy;
      oct_code_type code;
      s = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (z < 0 ? -z : z);
      code = '0;
      if (s == 0) begin
         code.zero_vector = 1'b1;
         return code;
      end
      // signed division truncates toward zero
      px = (x * UNIT_ONE) / s;
      py = (y * UNIT_ONE) / s;
      if (z < 0) begin
         fx = UNIT_ONE - (py < 0 ? -py : py);
         fy = UNIT_ONE - (px < 0 ? -px : px);
         // sign comes from the input, not the quotient
         px = (x < 0) ? -fx : fx;
         py = (y < 0) ? -fy : fy;
      end
      code.enc_x = onu_pkg::ENC_W'(quantize_coord(px, rmax));
      code.enc_y = onu_pkg::ENC_W'(quantize_coord(py, rmax));
      return code;
   endfunction

   always @(posedge clock) begin
      oct_code_type want;
      if (reset) begin
         pending_codes.delete();
         range_shadow = onu_pkg::RANGE_MAX_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[onu_pkg::CSR_ADDR_W-1] == onu_pkg::REG_RANGE_MAX) begin
            if (csr_pwrite) begin
               range_shadow = csr_pwdata[onu_pkg::RANGE_W-1:0];
            end else if (csr_prdata !== onu_pkg::CSR_DATA_W'(range_shadow)) begin
               $error("range_max readback: expected %0d, actual %0d",
                      range_shadow, csr_prdata);
               error_count++;
            end
         end
         if (req_valid && req_ready) begin
            pending_codes.push_back(octahedral_encode(longint'(req_comp_x),
                                                      longint'(req_comp_y),
                                                      longint'(req_comp_z),
                                                      longint'(range_shadow)));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_codes.size() == 0) begin
               $error("response transaction with no vector pending");
               error_count++;
            end else begin
               want = pending_codes.pop_front();
               if (rsp_enc_x !== want.enc_x) begin
                  $error("enc_x: expected %0d, actual %0d", want.enc_x, rsp_enc_x);
                  error_count++;
               end
               if (rsp_enc_y !== want.enc_y) begin
                  $error("enc_y: expected %0d, actual %0d", want.enc_y, rsp_enc_y);
                  error_count++;
               end
               if (rsp_zero_vector !== want.zero_vector) begin
                  $error("zero_vector: expected %0d, actual %0d",
                         want.zero_vector, rsp_zero_vector);
                  error_count++;
               end
            end
         end
      end
      outstanding = pending_codes.size();
   end

endmodule

// File: dv/oct_normal_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// oct_normal_encoder_unit_tb
// drives corner vectors and random vectors through the encoder under several
// range_max settings, with random gaps on both channels and two long response
// stalls; the checker predicts and compares every response
// ----------------------------------------------------------------------------
module oct_normal_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COMP_BITS    = 16;
   localparam int LATENCY      = COMP_BITS + 4;
   localparam int STALL_LIMIT  = 2000;   // cycles with no transaction at all
   localparam int HOLD_CYCLES  = 150;    // long response stall
   localparam int PHASE_ITEMS  = 150;
   localparam int N_PHASES     = 6;
   localparam int N_CORNERS    = 20;

   localparam logic [onu_pkg::CSR_ADDR_W-1:0] RANGE_MAX_ADDR =
      {onu_pkg::REG_RANGE_MAX, 2'b00};

   // component extremes
   localparam logic signed [COMP_BITS-1:0] C_NEG  = {1'b1, {(COMP_BITS-1){1'b0}}};
   localparam logic signed [COMP_BITS-1:0] C_POS  = {1'b0, {(COMP_BITS-1){1'b1}}};
   localparam logic signed [COMP_BITS-1:0] C_M1   = '1;
   localparam logic signed [COMP_BITS-1:0] C_P1   = 1;
   localparam logic signed [COMP_BITS-1:0] C_ZERO = '0;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] x;
      logic signed [COMP_BITS-1:0] y;
      logic signed [COMP_BITS-1:0] z;
   } vec3_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [COMP_BITS-1:0]         req_comp_x;
   logic signed [COMP_BITS-1:0]         req_comp_y;
   logic signed [COMP_BITS-1:0]         req_comp_z;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [onu_pkg::ENC_W-1:0]           rsp_enc_x;
   logic [onu_pkg::ENC_W-1:0]           rsp_enc_y;
   logic                                rsp_zero_vector;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [onu_pkg::CSR_ADDR_W-1:0]      csr_paddr;
   logic [onu_pkg::CSR_DATA_W-1:0]      csr_pwdata;
   logic [onu_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                csr_pready;
   int                                  error_count;
   int                                  outstanding;
   logic                                sender_burst;

   // corner vectors: axes, extremes, zero vector, lower hemisphere folds,
   // tiny negatives whose quotient truncates to zero
   vec3_type corner_cases [N_CORNERS] = '{
      '{C_ZERO, C_ZERO, C_ZERO},
      '{C_NEG,  C_ZERO, C_ZERO},
      '{C_POS,  C_ZERO, C_ZERO},
      '{C_ZERO, C_NEG,  C_ZERO},
      '{C_ZERO, C_POS,  C_ZERO},
      '{C_ZERO, C_ZERO, C_POS},
      '{C_ZERO, C_ZERO, C_NEG},
      '{C_NEG,  C_NEG,  C_NEG},
      '{C_POS,  C_POS,  C_POS},
      '{C_NEG,  C_POS,  C_NEG},
      '{C_M1,   C_M1,   C_NEG},
      '{C_P1,   C_M1,   C_NEG},
      '{C_M1,   C_ZERO, C_M1},
      '{C_ZERO, C_M1,   C_M1},
      '{C_P1,   C_P1,   C_P1},
      '{C_ZERO, C_ZERO, C_P1},
      '{C_ZERO, C_ZERO, C_M1},
      '{C_POS,  C_NEG,  C_P1},
      '{16'sd12345, -16'sd23456, -16'sd345},
      '{-16'sd7,    16'sd3,      -16'sd30000}
   };

   oct_normal_encoder_unit #(
      .COMP_BITS (COMP_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_comp_x      (req_comp_x),
      .req_comp_y      (req_comp_y),
      .req_comp_z      (req_comp_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_enc_x       (rsp_enc_x),
      .rsp_enc_y       (rsp_enc_y),
      .rsp_zero_vector (rsp_zero_vector),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   oct_normal_encoder_checker #(
      .COMP_BITS (COMP_BITS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_comp_x      (req_comp_x),
      .req_comp_y      (req_comp_y),
      .req_comp_z      (req_comp_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_enc_x       (rsp_enc_x),
      .rsp_enc_y       (rsp_enc_y),
      .rsp_zero_vector (rsp_zero_vector),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .error_count     (error_count),
      .outstanding     (outstanding)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one random component: mostly full range, sometimes zero, an extreme or
   // a small value near zero
   function automatic logic signed [COMP_BITS-1:0] pick_component();
      case ($urandom_range(0, 7))
         0: return C_ZERO;
         1: begin
            case ($urandom_range(0, 3))
               0: return C_NEG;
               1: return C_POS;
               2: return C_M1;
               default: return C_P1;
            endcase
         end
         2: return COMP_BITS'(int'($urandom_range(0, 32)) - 16);
         default: return COMP_BITS'($urandom);
      endcase
   endfunction

   // one vector transaction; called and returns at a falling edge
   task automatic send_vector(input vec3_type v);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_comp_x <= v.x;
      req_comp_y <= v.y;
      req_comp_z <= v.z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // setup then access cycle on range_max; a read is checked by the checker
   task automatic csr_access(input logic is_write,
                             input logic [onu_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= RANGE_MAX_ADDR;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int unsigned range_plan [N_PHASES];
      vec3_type    v;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_comp_x   = '0;
      req_comp_y   = '0;
      req_comp_z   = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      sender_burst = 1'b0;
      // extremes, the empty range, the reset value and two random settings
      range_plan = '{65535, 1, 0, 255, 0, 0};
      range_plan[4] = $urandom_range(2, 254);
      range_plan[5] = $urandom_range(256, 65534);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner vectors under the reset range
      foreach (corner_cases[i]) send_vector(corner_cases[i]);

      for (int p = 0; p < N_PHASES; p++) begin
         // register writes only with the pipeline empty
         req_valid <= 1'b0;
         wait (outstanding == 0);
         @(negedge clock);
         csr_access(1'b1, onu_pkg::CSR_DATA_W'(range_plan[p]));
         csr_access(1'b0, '0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // stretches of back-to-back transactions now and then
            if (i % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0) begin
               v = '0;
            end else begin
               v.x = pick_component();
               v.y = pick_component();
               v.z = pick_component();
            end
            send_vector(v);
         end
      end

      req_valid <= 1'b0;
      wait (outstanding == 0);
      // catch any response beyond the last expected one
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // response side: random ready gaps, burst stretches and two long stalls
   // that fill the pipeline and push back on req_ready
   initial begin : receiver
      int gap;
      int results_taken;
      logic recv_burst;
      rsp_ready     = 1'b0;
      results_taken = 0;
      recv_burst    = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (results_taken % 64 == 0) recv_burst = ($urandom_range(0, 3) == 0);
         gap = recv_burst ? 0 : $urandom_range(0, 7);
         if (results_taken == 200 || results_taken == 600) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         results_taken++;
         @(negedge clock);
      end
   end

   // watchdog: ends the run if no transaction moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule
